// ===== hdl/rtcc_pkg.sv =====
package rtcc_pkg;

    localparam int YearW = 14;
    localparam int MonW  = 4;
    localparam int DayW  = 5;
    localparam int HourW = 5;
    localparam int MinW  = 6;
    localparam int SecW  = 6;
    localparam int TickW = 16;

    localparam logic [YearW-1:0] YearMax   = 14'd9999;
    localparam logic [YearW-1:0] YearReset = 14'd2000;
    localparam logic [MonW-1:0]  MonMax    = 4'd12;
    localparam logic [HourW-1:0] HourMax   = 5'd23;
    localparam logic [MinW-1:0]  MinMax    = 6'd59;
    localparam logic [SecW-1:0]  SecMax    = 6'd59;

    localparam logic [TickW-1:0] TicksReset = 16'd5000;

    // reciprocal of 100 for years below 10000: q = (y * 5243) >> 19
    localparam int          RecipShift = 19;
    localparam logic [12:0] Recip100   = 13'd5243;

    localparam int CfgAddrW = 3;
    localparam int CfgDataW = 16;

    typedef enum logic [CfgAddrW-1:0] {
        REG_TICKS_PER_SECOND = 3'd0,
        REG_ALARM_HOUR       = 3'd1,
        REG_ALARM_MINUTE     = 3'd2,
        REG_ALARM_SECOND     = 3'd3,
        REG_OFFSET_HOURS     = 3'd4,
        REG_OFFSET_MINUTES   = 3'd5,
        REG_OFFSET_SECONDS   = 3'd6
    } t_cfg_reg;

    typedef enum logic {
        REQ_TICK = 1'b0,
        REQ_SET  = 1'b1
    } t_req_type;

    typedef struct packed {
        logic [TickW-1:0] ticks_per_second;
        logic [HourW-1:0] alarm_hour;
        logic [MinW-1:0]  alarm_minute;
        logic [SecW-1:0]  alarm_second;
        logic [HourW-1:0] offset_hours;
        logic [MinW-1:0]  offset_minutes;
        logic [SecW-1:0]  offset_seconds;
    } t_cfg;

    typedef struct packed {
        t_req_type        req_type;
        logic [YearW-1:0] set_year;
        logic [MonW-1:0]  set_month;
        logic [DayW-1:0]  set_day;
        logic [HourW-1:0] set_hour;
        logic [MinW-1:0]  set_minute;
        logic [SecW-1:0]  set_second;
    } t_req;

    typedef struct packed {
        logic [YearW-1:0] year;
        logic [MonW-1:0]  month;
        logic [DayW-1:0]  day;
        logic [HourW-1:0] hour;
        logic [MinW-1:0]  minute;
        logic [SecW-1:0]  second;
        logic             alarm;
    } t_time;

    function automatic logic is_leap(input logic [YearW-1:0] y);
        logic [26:0]      prod;
        logic [6:0]       q;
        logic [YearW-1:0] r;
        prod = 27'(y) * 27'(Recip100);
        q    = prod[RecipShift +: 7];
        r    = y - YearW'(q) * YearW'(100);
        return (y[1:0] == 2'd0) && ((r != '0) || (q[1:0] == 2'd0));
    endfunction

    function automatic logic [DayW-1:0] month_len(input logic [MonW-1:0] m,
                                                  input logic leap);
        logic [DayW-1:0] len;
        case (m) inside
            4'd2:                  len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            default:               len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ===== hdl/rtcc_cfg.sv =====
module rtcc_cfg
    import rtcc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_we,
    input  logic [CfgAddrW-1:0] i_addr,
    input  logic [CfgDataW-1:0] i_data,
    output t_cfg                o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ticks_per_second <= TicksReset;
            r_cfg.alarm_hour       <= '0;
            r_cfg.alarm_minute     <= '0;
            r_cfg.alarm_second     <= '0;
            r_cfg.offset_hours     <= '0;
            r_cfg.offset_minutes   <= MinW'(1);
            r_cfg.offset_seconds   <= '0;
        end else if (i_we) begin
            unique case (t_cfg_reg'(i_addr))
                REG_TICKS_PER_SECOND: r_cfg.ticks_per_second <= i_data[TickW-1:0];
                REG_ALARM_HOUR:       r_cfg.alarm_hour       <= i_data[HourW-1:0];
                REG_ALARM_MINUTE:     r_cfg.alarm_minute     <= i_data[MinW-1:0];
                REG_ALARM_SECOND:     r_cfg.alarm_second     <= i_data[SecW-1:0];
                REG_OFFSET_HOURS:     r_cfg.offset_hours     <= i_data[HourW-1:0];
                REG_OFFSET_MINUTES:   r_cfg.offset_minutes   <= i_data[MinW-1:0];
                REG_OFFSET_SECONDS:   r_cfg.offset_seconds   <= i_data[SecW-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hdl/rtcc_time.sv =====
module rtcc_time
    import rtcc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_step,
    input  t_req  i_req,
    input  t_cfg  i_cfg,
    output t_time o_next
);

    logic [TickW-1:0] r_tick;
    t_time            r_time;

    logic [TickW-1:0] n_tick;
    t_time            n_time;
    t_time            w_adv;
    t_time            w_set;
    logic [TickW:0]   w_tick_inc;
    logic             w_sec_adv;
    logic [DayW-1:0]  w_cur_len;
    logic [DayW-1:0]  w_set_len;
    logic [HourW:0]   w_hour_sum;
    logic [MinW:0]    w_min_sum;
    logic [SecW:0]    w_sec_sum;

    assign w_tick_inc = {1'b0, r_tick} + (TickW+1)'(1);
    assign w_sec_adv  = w_tick_inc >= {1'b0, i_cfg.ticks_per_second};
    assign w_cur_len  = month_len(r_time.month, is_leap(r_time.year));

    // advance one second
    always_comb begin
        w_adv = r_time;
        if (r_time.second != SecMax) begin
            w_adv.second = r_time.second + SecW'(1);
        end else begin
            w_adv.second = '0;
            if (r_time.minute != MinMax) begin
                w_adv.minute = r_time.minute + MinW'(1);
            end else begin
                w_adv.minute = '0;
                if (r_time.hour != HourMax) begin
                    w_adv.hour = r_time.hour + HourW'(1);
                end else begin
                    w_adv.hour = '0;
                    if (r_time.day < w_cur_len) begin
                        w_adv.day = r_time.day + DayW'(1);
                    end else begin
                        w_adv.day = DayW'(1);
                        if (r_time.month < MonMax) begin
                            w_adv.month = r_time.month + MonW'(1);
                        end else begin
                            w_adv.month = MonW'(1);
                            w_adv.year  = (r_time.year >= YearMax) ? '0
                                        : r_time.year + YearW'(1);
                        end
                    end
                end
            end
        end
    end

    // clamp loaded fields
    always_comb begin
        w_set        = r_time;
        w_set.year   = (i_req.set_year > YearMax) ? YearMax : i_req.set_year;
        w_set.month  = (i_req.set_month == '0) ? MonW'(1)
                     : (i_req.set_month > MonMax) ? MonMax : i_req.set_month;
        w_set_len    = month_len(w_set.month, is_leap(w_set.year));
        w_set.day    = (i_req.set_day == '0) ? DayW'(1)
                     : (i_req.set_day > w_set_len) ? w_set_len : i_req.set_day;
        w_set.hour   = (i_req.set_hour > HourMax) ? HourMax : i_req.set_hour;
        w_set.minute = (i_req.set_minute > MinMax) ? MinMax : i_req.set_minute;
        w_set.second = (i_req.set_second > SecMax) ? SecMax : i_req.set_second;
    end

    assign w_hour_sum = {1'b0, i_cfg.alarm_hour} + {1'b0, i_cfg.offset_hours};
    assign w_min_sum  = {1'b0, i_cfg.alarm_minute} + {1'b0, i_cfg.offset_minutes};
    assign w_sec_sum  = {1'b0, i_cfg.alarm_second} + {1'b0, i_cfg.offset_seconds};

    always_comb begin
        n_tick = r_tick;
        n_time = r_time;
        if (i_req.req_type == REQ_SET) begin
            n_time = w_set;
        end else begin
            n_tick = w_sec_adv ? '0 : w_tick_inc[TickW-1:0];
            if (w_sec_adv) begin
                n_time = w_adv;
            end
        end
        if (n_time.hour == i_cfg.alarm_hour && n_time.minute == i_cfg.alarm_minute
            && n_time.second == i_cfg.alarm_second) begin
            n_time.alarm = 1'b0;
        end
        if ({1'b0, n_time.hour} == w_hour_sum && {1'b0, n_time.minute} == w_min_sum
            && {1'b0, n_time.second} == w_sec_sum) begin
            n_time.alarm = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick        <= '0;
            r_time.year   <= YearReset;
            r_time.month  <= MonW'(1);
            r_time.day    <= DayW'(1);
            r_time.hour   <= '0;
            r_time.minute <= '0;
            r_time.second <= '0;
            r_time.alarm  <= 1'b1;
        end else if (i_step) begin
            r_tick <= n_tick;
            r_time <= n_time;
        end
    end

    assign o_next = n_time;

endmodule

// ===== hdl/rtc_calendar_with_alarm_core.sv =====
// Real-time clock and calendar with an alarm output level.
// Input stream: one word per request. s_axis_tuser = req_type (0 tick, 1 load
// date and time); s_axis_tdata carries the date and time to load.
// Output stream: one word per request, giving date, time and alarm level
// after that request.
// Configuration: i_cfg_we / i_cfg_addr / i_cfg_data write one register per
// cycle (0 ticks per second, 1..3 alarm time, 4..6 offsets); index 7 is ignored.
// Path from input accept to output valid: input register, then one pass of
// counter, carry and leap logic into the output register.
// Throughput: one word per cycle unless the output stalls; the calendar state
// feeds back within that single pass so consecutive words follow with no gap.
// A stalled receiver holds the output word; the input register still takes
// one more word, after which s_axis_tready drops until the output moves.
// Reset (synchronous, active low): 2000-01-01 00:00:00, prescaler 0, alarm
// level 1, registers at their defaults, both stages empty.
module rtc_calendar_with_alarm_core
    import rtcc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgAddrW-1:0] i_cfg_addr,
    input  logic [CfgDataW-1:0] i_cfg_data,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // set_year[13:0], set_month[17:14], set_day[22:18], set_hour[27:23],
    // set_minute[33:28], set_second[39:34]
    input  logic [39:0]         s_axis_tdata,
    // req_type[0]
    input  logic                s_axis_tuser,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // now_year[13:0], now_month[17:14], now_day[22:18], now_hour[27:23],
    // now_minute[33:28], now_second[39:34], alarm_line[40], zero[47:41]
    output logic [47:0]         m_axis_tdata
);

    t_cfg  w_cfg;
    t_req  r_req;
    t_time w_next;
    t_time r_out;
    logic  r_s1_valid;
    logic  r_out_valid;
    logic  w_adv;
    logic  w_step;

    rtcc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_addr  (i_cfg_addr),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    assign w_adv         = !r_out_valid || m_axis_tready;
    assign w_step        = r_s1_valid && w_adv;
    assign s_axis_tready = !r_s1_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_req.req_type   <= t_req_type'(s_axis_tuser);
            r_req.set_year   <= s_axis_tdata[13:0];
            r_req.set_month  <= s_axis_tdata[17:14];
            r_req.set_day    <= s_axis_tdata[22:18];
            r_req.set_hour   <= s_axis_tdata[27:23];
            r_req.set_minute <= s_axis_tdata[33:28];
            r_req.set_second <= s_axis_tdata[39:34];
        end
    end

    rtcc_time u_time (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_req   (r_req),
        .i_cfg   (w_cfg),
        .o_next  (w_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_next;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out.alarm, r_out.second, r_out.minute,
                            r_out.hour, r_out.day, r_out.month, r_out.year};

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    a_step_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |=> m_axis_tvalid)
        else $error("processed word did not reach the output");

    a_month_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_out.month != '0 && r_out.month <= MonMax))
        else $error("month out of range");

    a_time_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_out.day != '0 && r_out.second <= SecMax
                           && r_out.minute <= MinMax && r_out.hour <= HourMax))
        else $error("time field out of range");

endmodule
